FILE: rtl/core/mcca_pkg.sv
`timescale 1ns / 1ps

package mcca_pkg;

    // Register map of the configuration port
    localparam logic [7:0] CFG_TICK_PERIOD = 8'd0;
    localparam logic [7:0] CFG_MIN_DELAY   = 8'd1;

    localparam logic [19:0] TICK_PERIOD_RESET = 20'd10000;
    localparam logic [19:0] MIN_DELAY_RESET   = 20'd10;

    localparam logic [19:0] USEC_PER_SEC = 20'd1000000;

    // 1000000 = 64 * 15625: drop six bits, then divide by the odd factor
    // one 16-bit digit at a time.
    localparam logic [13:0] DIV_ODD     = 14'd15625;
    localparam int          DIGITS      = 3;
    localparam int          DIGIT_W     = 16;
    localparam int          RECIP_SHIFT = 44;
    // floor(2^44 / 15625); the estimate it gives is low by at most one
    localparam logic [30:0] RECIP_M     = 31'd1125899906;

    // One item on its way down the pipeline
    typedef struct packed {
        logic        advanced;
        logic [31:0] now_low;
        logic        head_valid;
        logic [31:0] head_secs;
        logic [19:0] head_micro;
        logic [47:0] chunks;   // bits 53:6 of the booked count
        logic [5:0]  b_low6;   // bits 5:0 of the booked count
        logic [13:0] rem;      // running remainder modulo 15625
        logic [31:0] secs;     // quotient digits shifted in
    } t_item;

endpackage

FILE: rtl/core/microsecond_clock_and_compare_arm.sv
`timescale 1ns / 1ps

// Microsecond clock and compare arm. Each input transaction carries a
// reading of the free-running 64-bit 1 MHz counter and, optionally, the
// deadline of the earliest pending request. A reading past the last booked
// value is booked; wall time and elapsed time both run from zero by the
// booked differences, so both equal the booked count split into seconds
// (modulo 2^32) and microseconds. The block then arms a delay: the tick
// period, cut to the time left before the request deadline, zero once that
// deadline is due, never below the minimum delay. The result transaction
// gives the compare target (low counter word plus delay, wrapping), the
// delay, the advanced flag and both times. One transaction is accepted per
// cycle while the result side does not stall; the seconds split divides the
// booked count, less its low six bits, by 15625 in three 16-bit digits,
// each a reciprocal multiply followed by a correction stage. Configuration
// writes are taken at any time but are meant for when the pipeline is empty.
module microsecond_clock_and_compare_arm (
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [63:0] i_counter_now,
    input  logic        i_head_valid,
    input  logic [31:0] i_head_secs,
    input  logic [19:0] i_head_micro,

    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [31:0] o_compare_value,
    output logic [19:0] o_chosen_delay,
    output logic        o_advanced,
    output logic [31:0] o_wall_secs,
    output logic [19:0] o_wall_micro,
    output logic [31:0] o_run_secs,
    output logic [19:0] o_run_micro,

    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [7:0]  i_cfg_index,
    input  logic [19:0] i_cfg_data
);

    // Stage map: input, (multiply, correct) per digit, deadline, result
    localparam int NUM_ST = 3 + 2 * mcca_pkg::DIGITS;
    localparam int ST_D1  = NUM_ST - 2;
    localparam int ST_OUT = NUM_ST - 1;
    localparam int PROD_W = 61;

    logic [19:0]          r_tick;
    logic [19:0]          r_min;
    logic [63:0]          r_booked;

    logic                 r_vld  [0:NUM_ST-1];
    logic                 rdy    [0:NUM_ST-1];
    mcca_pkg::t_item      r_item [0:NUM_ST-1];

    logic [29:0]          r_v    [0:mcca_pkg::DIGITS-1];
    logic [15:0]          r_q    [0:mcca_pkg::DIGITS-1];
    logic [29:0]          w_v    [0:mcca_pkg::DIGITS-1];
    logic [PROD_W-1:0]    w_prod [0:mcca_pkg::DIGITS-1];
    logic [29:0]          w_r0   [0:mcca_pkg::DIGITS-1];
    logic                 w_fix  [0:mcca_pkg::DIGITS-1];
    mcca_pkg::t_item      w_cor  [0:mcca_pkg::DIGITS-1];

    logic                 in_acc;
    logic                 n_adv;
    logic [63:0]          n_booked;

    // deadline stage
    logic [31:0]          d1_run_sec;
    logic [19:0]          d1_run_usec;
    logic                 d1_due;
    logic                 d1_borrow;
    logic [31:0]          d1_sdiff;
    logic                 d1_lsec_zero;
    logic [20:0]          d1_lusec;
    logic                 r_due;
    logic                 r_lsec_zero;
    logic [20:0]          r_lusec;

    // result stage
    logic [19:0]          n_delay;
    logic [19:0]          r_delay;
    logic [31:0]          r_target;

    //----------------------------------------------------------------------
    // Configuration: always ready, writes to unknown indexes drop
    //----------------------------------------------------------------------
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick <= mcca_pkg::TICK_PERIOD_RESET;
            r_min  <= mcca_pkg::MIN_DELAY_RESET;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == mcca_pkg::CFG_TICK_PERIOD) begin
                r_tick <= i_cfg_data;
            end else if (i_cfg_index == mcca_pkg::CFG_MIN_DELAY) begin
                r_min <= i_cfg_data;
            end
        end
    end

    //----------------------------------------------------------------------
    // Pipeline flow: a stage takes new data when empty or moving on
    //----------------------------------------------------------------------
    always_comb begin
        rdy[ST_OUT] = !r_vld[ST_OUT] || i_out_ready;
        for (int k = ST_OUT - 1; k >= 0; k--) begin
            rdy[k] = !r_vld[k] || rdy[k + 1];
        end
    end

    assign o_in_ready = rdy[0];
    assign in_acc     = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_ST; k++) begin
                r_vld[k] <= 1'b0;
            end
        end else begin
            if (rdy[0]) begin
                r_vld[0] <= i_in_valid;
            end
            for (int k = 1; k < NUM_ST; k++) begin
                if (rdy[k]) begin
                    r_vld[k] <= r_vld[k - 1];
                end
            end
        end
    end

    //----------------------------------------------------------------------
    // Input stage: book the reading if it is ahead of the booked count.
    // Both clocks always equal the booked count in seconds and microseconds.
    //----------------------------------------------------------------------
    assign n_adv    = i_counter_now > r_booked;
    assign n_booked = n_adv ? i_counter_now : r_booked;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_booked <= '0;
        end else if (in_acc) begin
            r_booked <= n_booked;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy[0]) begin
            r_item[0].advanced   <= n_adv;
            r_item[0].now_low    <= i_counter_now[31:0];
            r_item[0].head_valid <= i_head_valid;
            r_item[0].head_secs  <= i_head_secs;
            r_item[0].head_micro <= i_head_micro;
            r_item[0].chunks     <= n_booked[53:6];
            r_item[0].b_low6     <= n_booked[5:0];
            r_item[0].rem        <= 14'(n_booked[63:54]);
            r_item[0].secs       <= '0;
        end
    end

    //----------------------------------------------------------------------
    // Seconds split: one 16-bit quotient digit per multiply/correct pair
    //----------------------------------------------------------------------
    for (genvar k = 0; k < mcca_pkg::DIGITS; k++) begin : g_digit
        localparam int SRC = 2 * k;
        localparam int MUL = 2 * k + 1;
        localparam int COR = 2 * k + 2;
        localparam int HI  = 47 - mcca_pkg::DIGIT_W * k;

        always_comb begin
            w_v[k]    = {r_item[SRC].rem, r_item[SRC].chunks[HI -: mcca_pkg::DIGIT_W]};
            w_prod[k] = PROD_W'(w_v[k]) * PROD_W'(mcca_pkg::RECIP_M);
        end

        always_ff @(posedge i_clk) begin
            if (rdy[MUL]) begin
                r_item[MUL] <= r_item[SRC];
                r_v[k]      <= w_v[k];
                r_q[k]      <= w_prod[k][mcca_pkg::RECIP_SHIFT + 15 : mcca_pkg::RECIP_SHIFT];
            end
        end

        // estimate is exact or one low: fix with a single compare and subtract
        always_comb begin
            w_r0[k]       = r_v[k] - 30'(r_q[k]) * 30'(mcca_pkg::DIV_ODD);
            w_fix[k]      = w_r0[k] >= 30'(mcca_pkg::DIV_ODD);
            w_cor[k]      = r_item[MUL];
            w_cor[k].rem  = w_fix[k] ? 14'(w_r0[k] - 30'(mcca_pkg::DIV_ODD))
                                     : 14'(w_r0[k]);
            w_cor[k].secs = {r_item[MUL].secs[15:0], r_q[k] + 16'(w_fix[k])};
        end

        always_ff @(posedge i_clk) begin
            if (rdy[COR]) begin
                r_item[COR] <= w_cor[k];
            end
        end
    end

    //----------------------------------------------------------------------
    // Deadline stage: due check and time left with a microsecond borrow
    //----------------------------------------------------------------------
    always_comb begin
        d1_run_sec   = r_item[ST_D1 - 1].secs;
        d1_run_usec  = {r_item[ST_D1 - 1].rem, r_item[ST_D1 - 1].b_low6};
        d1_due       = (d1_run_sec > r_item[ST_D1 - 1].head_secs) ||
                       ((d1_run_sec == r_item[ST_D1 - 1].head_secs) &&
                        (d1_run_usec >= r_item[ST_D1 - 1].head_micro));
        d1_borrow    = r_item[ST_D1 - 1].head_micro < d1_run_usec;
        d1_sdiff     = r_item[ST_D1 - 1].head_secs - d1_run_sec;
        d1_lsec_zero = d1_borrow ? (d1_sdiff == 32'd1) : (d1_sdiff == 32'd0);
        if (d1_borrow) begin
            d1_lusec = 21'(r_item[ST_D1 - 1].head_micro) + 21'(mcca_pkg::USEC_PER_SEC)
                       - 21'(d1_run_usec);
        end else begin
            d1_lusec = 21'(r_item[ST_D1 - 1].head_micro) - 21'(d1_run_usec);
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy[ST_D1]) begin
            r_item[ST_D1] <= r_item[ST_D1 - 1];
            r_due         <= d1_due;
            r_lsec_zero   <= d1_lsec_zero;
            r_lusec       <= d1_lusec;
        end
    end

    //----------------------------------------------------------------------
    // Result stage: pick the delay, clamp to the minimum, form the target
    //----------------------------------------------------------------------
    always_comb begin
        n_delay = r_tick;
        if (r_item[ST_D1].head_valid) begin
            if (r_due) begin
                n_delay = '0;
            end else if (r_lsec_zero && (r_lusec < 21'(r_tick))) begin
                n_delay = r_lusec[19:0];
            end
        end
        if (n_delay < r_min) begin
            n_delay = r_min;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy[ST_OUT]) begin
            r_item[ST_OUT] <= r_item[ST_D1];
            r_delay        <= n_delay;
            r_target       <= r_item[ST_D1].now_low + 32'(n_delay);
        end
    end

    assign o_out_valid     = r_vld[ST_OUT];
    assign o_compare_value = r_target;
    assign o_chosen_delay  = r_delay;
    assign o_advanced      = r_item[ST_OUT].advanced;
    assign o_wall_secs     = r_item[ST_OUT].secs;
    assign o_wall_micro    = {r_item[ST_OUT].rem, r_item[ST_OUT].b_low6};
    assign o_run_secs      = r_item[ST_OUT].secs;
    assign o_run_micro     = {r_item[ST_OUT].rem, r_item[ST_OUT].b_low6};

    //----------------------------------------------------------------------
    // Checks
    //----------------------------------------------------------------------
    a_book_ahead: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && (i_counter_now > r_booked)) |=> (r_booked == $past(i_counter_now)))
        else $error("booked count did not take a reading that was ahead");

    a_book_mono: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rst_n |=> (r_booked >= $past(r_booked)))
        else $error("booked count went backward");

    a_rem_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[ST_D1 - 1] |-> (r_item[ST_D1 - 1].rem < mcca_pkg::DIV_ODD))
        else $error("seconds split remainder out of range");

    a_min_delay: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_chosen_delay >= r_min))
        else $error("armed delay below minimum");

    a_target: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_compare_value == r_item[ST_OUT].now_low + 32'(o_chosen_delay)))
        else $error("compare target does not match delay");

endmodule
